FILE: hdl/kvt_pkg.sv
`default_nettype none
package kvt_pkg;

  localparam logic [7:0] KEY_FIRST = 8'h3A;
  localparam logic [7:0] KEY_LAST  = 8'h52;
  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_TILDE  = 8'h7E;  // '~'
  localparam logic [7:0] CH_ONE    = 8'h31;  // '1'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [4:0] MOD_PLAIN = 5'd1;
  localparam int         MAX_BYTES = 8;

  // one key table entry: lead is 'O' or '[' for the short form, 0 for numbered
  typedef struct packed {
    logic [7:0] lead;
    logic [7:0] val;
  } key_entry_t;

  // one decoded sequence handed from front to back
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] seq;
    logic [2:0]                last_idx;
  } seq_desc_t;

  // key table, indexed by usage minus KEY_FIRST
  function automatic key_entry_t kvt_key_entry(input logic [4:0] idx);
    key_entry_t e;
    e = '{lead: 8'h00, val: 8'h00};
    case (idx)
      5'd0:  e = '{lead: 8'h4F, val: 8'h50};
      5'd1:  e = '{lead: 8'h4F, val: 8'h51};
      5'd2:  e = '{lead: 8'h4F, val: 8'h52};
      5'd3:  e = '{lead: 8'h4F, val: 8'h53};
      5'd4:  e.val = 8'd15;
      5'd5:  e.val = 8'd17;
      5'd6:  e.val = 8'd18;
      5'd7:  e.val = 8'd19;
      5'd8:  e.val = 8'd20;
      5'd9:  e.val = 8'd21;
      5'd10: e.val = 8'd23;
      5'd11: e.val = 8'd24;
      5'd15: e.val = 8'd2;
      5'd16: e = '{lead: 8'h5B, val: 8'h48};
      5'd17: e.val = 8'd5;
      5'd18: e.val = 8'd3;
      5'd19: e = '{lead: 8'h5B, val: 8'h46};
      5'd20: e.val = 8'd6;
      5'd21: e = '{lead: 8'h5B, val: 8'h43};
      5'd22: e = '{lead: 8'h5B, val: 8'h44};
      5'd23: e = '{lead: 8'h5B, val: 8'h42};
      5'd24: e = '{lead: 8'h5B, val: 8'h41};
      default: e = '{lead: 8'h00, val: 8'h00};
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/kvt_front.sv
`default_nettype none
module kvt_front
  import kvt_pkg::*;
(
  input  wire logic [7:0] key_usage,
  input  wire logic [4:0] modifier_code,
  output seq_desc_t       desc,
  output logic            has_seq
);

  // tens digit of a value below 32
  function automatic logic [1:0] dec_tens(input logic [4:0] v);
    logic [1:0] t;
    if (v >= 5'd30) begin
      t = 2'd3;
    end else if (v >= 5'd20) begin
      t = 2'd2;
    end else if (v >= 5'd10) begin
      t = 2'd1;
    end else begin
      t = 2'd0;
    end
    return t;
  endfunction

  // ascii digit for a value below 10
  function automatic logic [7:0] dec_char(input logic [3:0] d);
    return CH_ZERO + {4'd0, d};
  endfunction

  logic [4:0]  idx;
  logic        in_range;
  key_entry_t  ent;
  logic [1:0]  mod_tens;
  logic [4:0]  mod_ones;
  logic [1:0]  num_tens;
  logic [4:0]  num_ones;
  logic [4:0]  num_val;
  logic        plain;

  // table lookup and digit split
  always_comb begin
    idx      = 5'(key_usage - KEY_FIRST);
    in_range = (key_usage >= KEY_FIRST) && (key_usage <= KEY_LAST);
    ent      = kvt_key_entry(idx);
    num_val  = ent.val[4:0];
    plain    = (modifier_code == MOD_PLAIN);
    mod_tens = dec_tens(modifier_code);
    mod_ones = modifier_code - 5'(mod_tens) * 5'd10;
    num_tens = dec_tens(num_val);
    num_ones = num_val - 5'(num_tens) * 5'd10;
    has_seq  = in_range && ((ent.lead != 8'h00) || (ent.val != 8'h00));
  end

  // assemble the byte string
  always_comb begin
    logic [3:0] n;
    desc = '0;
    n    = 4'd0;
    desc.seq[n[2:0]] = ESC_BYTE;
    n = n + 4'd1;
    if (ent.lead != 8'h00) begin
      if (plain) begin
        desc.seq[n[2:0]] = ent.lead;
        n = n + 4'd1;
      end else begin
        desc.seq[n[2:0]] = CH_LBRACK;
        n = n + 4'd1;
        desc.seq[n[2:0]] = CH_ONE;
        n = n + 4'd1;
        desc.seq[n[2:0]] = CH_SEMI;
        n = n + 4'd1;
        if (mod_tens != 2'd0) begin
          desc.seq[n[2:0]] = dec_char({2'd0, mod_tens});
          n = n + 4'd1;
        end
        desc.seq[n[2:0]] = dec_char(mod_ones[3:0]);
        n = n + 4'd1;
      end
      desc.seq[n[2:0]] = ent.val;
      n = n + 4'd1;
    end else begin
      desc.seq[n[2:0]] = CH_LBRACK;
      n = n + 4'd1;
      if (num_tens != 2'd0) begin
        desc.seq[n[2:0]] = dec_char({2'd0, num_tens});
        n = n + 4'd1;
      end
      desc.seq[n[2:0]] = dec_char(num_ones[3:0]);
      n = n + 4'd1;
      if (!plain) begin
        desc.seq[n[2:0]] = CH_SEMI;
        n = n + 4'd1;
        if (mod_tens != 2'd0) begin
          desc.seq[n[2:0]] = dec_char({2'd0, mod_tens});
          n = n + 4'd1;
        end
        desc.seq[n[2:0]] = dec_char(mod_ones[3:0]);
        n = n + 4'd1;
      end
      desc.seq[n[2:0]] = CH_TILDE;
      n = n + 4'd1;
    end
    desc.last_idx = 3'(n - 4'd1);
  end

endmodule
`default_nettype wire

FILE: hdl/kvt_desc_fifo.sv
`default_nettype none
module kvt_desc_fifo
  import kvt_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  wire seq_desc_t wr_desc,
  input  wire logic      rd_en,
  output seq_desc_t      rd_desc,
  output logic           full,
  output logic           nonempty
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  seq_desc_t          mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full     = (count_r == CNT_W'(QDEPTH));
  assign nonempty = (count_r != '0);
  assign rd_desc  = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/kvt_back.sv
`default_nettype none
module kvt_back
  import kvt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       desc_avail,
  input  wire seq_desc_t  desc,
  output logic            desc_done,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_seq_byte,
  output logic            out_last_byte
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic       at_end;

  // take the next byte when the output register is free or being drained
  always_comb begin
    load      = desc_avail && (!valid_r || out_pop);
    at_end    = (idx_r == desc.last_idx);
    desc_done = load && at_end;
    idx_nxt   = idx_r;
    if (load) begin
      idx_nxt = at_end ? 3'd0 : idx_r + 3'd1;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= desc.seq[idx_r];
      last_r <= at_end;
    end
  end

  assign out_empty     = !valid_r;
  assign out_seq_byte  = byte_r;
  assign out_last_byte = last_r;

endmodule
`default_nettype wire

FILE: hdl/key_to_vt_escape_sequence.sv
// Function and navigation key to terminal escape sequence encoder.
// Input side is a queue push port: in_key_usage and in_modifier_code are
// taken on a clock edge with in_push high and in_full low. Each key beat is
// decoded at once and its whole byte string (up to 8 bytes) is stored in a
// descriptor queue of QDEPTH entries; keys with no sequence store nothing.
// Result side is a queue pop port: while out_empty is low, out_seq_byte and
// out_last_byte show the oldest byte; it is taken on an edge with out_pop
// high. out_last_byte marks the final byte of each sequence.
// The first byte of a key passes the descriptor queue and then the output byte
// register. Throughput: one byte per cycle while out_pop stays high; a sequence
// has 3 to 8 bytes, and the output byte register sets this rate.
// in_full rises only when QDEPTH sequences wait, so keys keep flowing while
// bytes drain. If the receiver stalls, the current byte holds and the queue
// fills, then in_full rises. Synchronous reset empties the queue and the
// output register; no sequence in flight survives it.
`default_nettype none
module key_to_vt_escape_sequence
  import kvt_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_key_usage,
  input  wire logic [4:0] in_modifier_code,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_seq_byte,
  output logic            out_last_byte
);

  seq_desc_t front_desc;
  seq_desc_t head_desc;
  logic      has_seq;
  logic      q_wr;
  logic      q_rd;
  logic      q_nonempty;

  // decode
  kvt_front u_front (
    .key_usage     (in_key_usage),
    .modifier_code (in_modifier_code),
    .desc          (front_desc),
    .has_seq       (has_seq)
  );

  assign q_wr = in_push && !in_full && has_seq;

  // descriptor queue
  kvt_desc_fifo #(.QDEPTH(QDEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_desc  (front_desc),
    .rd_en    (q_rd),
    .rd_desc  (head_desc),
    .full     (in_full),
    .nonempty (q_nonempty)
  );

  // byte emitter
  kvt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .desc_avail    (q_nonempty),
    .desc          (head_desc),
    .desc_done     (q_rd),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_seq_byte  (out_seq_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
`default_nettype wire

FILE: hdl/kvt_checker.sv
`default_nettype none
module kvt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [7:0] out_seq_byte,
  input wire logic       out_last_byte
);

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("not idle after reset");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_seq_byte) && $stable(out_last_byte)))
    else $error("stalled beat changed");

  // a new sequence opens with escape
  a_start_esc: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_last_byte) |=>
      (out_empty || out_seq_byte == 8'h1B))
    else $error("sequence does not start with escape");

  // the final byte is a tilde or a final letter
  a_last_char: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last_byte) |->
      (out_seq_byte == 8'h7E || (out_seq_byte >= 8'h41 && out_seq_byte <= 8'h53)))
    else $error("bad final byte");

  // a tilde only ever closes a sequence
  a_tilde_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_seq_byte == 8'h7E) |-> out_last_byte)
    else $error("tilde inside a sequence");

endmodule

bind key_to_vt_escape_sequence kvt_checker u_kvt_checker (.*);
`default_nettype wire
